// File: rtl/core/crir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collision impulse response package
// Shared types, constants and helpers for the 2D impulse resolution pipeline.
// ----------------------------------------------------------------------------
package crir_pkg;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_PERCENT = 2'd0;
  localparam logic [1:0] REG_SLOP    = 2'd1;

  localparam logic [16:0] Q_ONE       = 17'h10000;
  localparam logic [16:0] PERCENT_RST = 17'd6554;
  localparam logic [30:0] SLOP_RST    = 31'd6554;
  localparam int unsigned DIV_STAGES  = 30;

  // Payload that travels alongside the weight divider.
  typedef struct packed {
    logic [63:0] vel_a;
    logic [63:0] vel_b;
    logic [63:0] pos_a;
    logic [63:0] pos_b;
    logic [63:0] normal;
    logic [31:0] k;
    logic [31:0] q;
    logic        applied;
    logic        sat;
  } mid_t;

  // Divider result together with its payload.
  typedef struct packed {
    mid_t        mid;
    logic [29:0] wa;
    logic        rem_nz;
  } div_t;

  // Clamp a wide signed value to Q16.16; the top bit flags a clamp.
  function automatic logic [32:0] clamp32(input logic signed [49:0] v);
    logic [32:0] r;
    if (v > 50'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -50'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

// File: rtl/core/crir_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front pipeline
// Normal speed of the relative velocity, impulse magnitude and correction
// depth, in four register stages.
// ----------------------------------------------------------------------------
module crir_front import crir_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [63:0] vel_a_i,
  input  logic [63:0] vel_b_i,
  input  logic [63:0] pos_a_i,
  input  logic [63:0] pos_b_i,
  input  logic [63:0] normal_i,
  input  logic [30:0] penetration_i,
  input  logic [30:0] mass_a_i,
  input  logic [30:0] mass_b_i,
  input  logic [16:0] restitution_a_i,
  input  logic [16:0] restitution_b_i,
  input  logic [16:0] percent_i,
  input  logic [30:0] slop_i,
  output logic        valid_o,
  output mid_t        mid_o,
  output logic [30:0] mb_o,
  output logic [31:0] s_o
);

  // Stage 1: operand cleanup and relative velocity.
  logic [63:0]        va1_q, vb1_q, pa1_q, pb1_q, n1_q;
  logic signed [32:0] rvx1_q, rvy1_q;
  logic [30:0]        ma1_q, mb1_q, d1_q;
  logic [17:0]        e1_q;
  logic [16:0]        pct1_q;
  logic [16:0]        ra_c, rb_c, e_min, pct_c;

  always_comb begin
    ra_c  = (restitution_a_i > Q_ONE) ? Q_ONE : restitution_a_i;
    rb_c  = (restitution_b_i > Q_ONE) ? Q_ONE : restitution_b_i;
    e_min = (ra_c < rb_c) ? ra_c : rb_c;
    pct_c = (percent_i > Q_ONE) ? Q_ONE : percent_i;
  end

  // Stage 2: normal products, correction depth, mass sum.
  logic [63:0]        va2_q, vb2_q, pa2_q, pb2_q, n2_q;
  logic signed [64:0] px2_q, py2_q;
  logic [31:0]        q2_q, s2_q;
  logic [30:0]        mb2_q;
  logic [17:0]        e2_q;
  logic signed [64:0] px_d, py_d;
  logic [47:0]        qp_d;

  assign px_d = 65'(rvx1_q) * 65'($signed(n1_q[63:32]));
  assign py_d = 65'(rvy1_q) * 65'($signed(n1_q[31:0]));
  assign qp_d = 48'(d1_q) * 48'(pct1_q);

  // Stage 3: normal speed and clamped closing speed.
  logic [63:0]        va3_q, vb3_q, pa3_q, pb3_q, n3_q;
  logic [31:0]        u3_q, q3_q, s3_q;
  logic [30:0]        mb3_q;
  logic [17:0]        e3_q;
  logic               app3_q, usat3_q;
  logic signed [49:0] vn_d, negvn_d;
  logic               app_d, big_d;

  always_comb begin
    vn_d    = 50'(px2_q >>> 16) + 50'(py2_q >>> 16);
    negvn_d = -vn_d;
    app_d   = vn_d[49] || (vn_d == '0);
    big_d   = |negvn_d[49:32];
  end

  // Stage 4: impulse scaled by one plus restitution.
  logic [49:0] kp_d;
  logic        ksat_d;

  assign kp_d   = 50'(u3_q) * 50'(e3_q);
  assign ksat_d = |kp_d[49:48];

  logic v1_q, v2_q, v3_q, v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      va1_q  <= vel_a_i;
      vb1_q  <= vel_b_i;
      pa1_q  <= pos_a_i;
      pb1_q  <= pos_b_i;
      n1_q   <= normal_i;
      rvx1_q <= $signed({vel_b_i[63], vel_b_i[63:32]}) - $signed({vel_a_i[63], vel_a_i[63:32]});
      rvy1_q <= $signed({vel_b_i[31], vel_b_i[31:0]}) - $signed({vel_a_i[31], vel_a_i[31:0]});
      ma1_q  <= (mass_a_i == '0) ? 31'd1 : mass_a_i;
      mb1_q  <= (mass_b_i == '0) ? 31'd1 : mass_b_i;
      d1_q   <= (penetration_i > slop_i) ? (penetration_i - slop_i) : '0;
      e1_q   <= {1'b0, Q_ONE} + {1'b0, e_min};
      pct1_q <= pct_c;

      va2_q <= va1_q;
      vb2_q <= vb1_q;
      pa2_q <= pa1_q;
      pb2_q <= pb1_q;
      n2_q  <= n1_q;
      px2_q <= px_d;
      py2_q <= py_d;
      q2_q  <= qp_d[47:16];
      s2_q  <= {1'b0, ma1_q} + {1'b0, mb1_q};
      mb2_q <= mb1_q;
      e2_q  <= e1_q;

      va3_q   <= va2_q;
      vb3_q   <= vb2_q;
      pa3_q   <= pa2_q;
      pb3_q   <= pb2_q;
      n3_q    <= n2_q;
      u3_q    <= !app_d ? '0 : (big_d ? 32'hFFFF_FFFF : negvn_d[31:0]);
      usat3_q <= app_d && big_d;
      app3_q  <= app_d;
      q3_q    <= q2_q;
      s3_q    <= s2_q;
      mb3_q   <= mb2_q;
      e3_q    <= e2_q;

      mid_o.vel_a   <= va3_q;
      mid_o.vel_b   <= vb3_q;
      mid_o.pos_a   <= pa3_q;
      mid_o.pos_b   <= pb3_q;
      mid_o.normal  <= n3_q;
      mid_o.k       <= ksat_d ? 32'hFFFF_FFFF : kp_d[47:16];
      mid_o.q       <= q3_q;
      mid_o.applied <= app3_q;
      mid_o.sat     <= usat3_q || ksat_d;
      mb_o          <= mb3_q;
      s_o           <= s3_q;
    end
  end

  assign valid_o = v4_q;

endmodule

// File: rtl/core/crir_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weight divider
// Restoring divider, one quotient bit per stage, for wa = mb * 2^30 / (ma+mb).
// ----------------------------------------------------------------------------
module crir_div import crir_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  mid_t        mid_i,
  input  logic [30:0] mb_i,
  input  logic [31:0] s_i,
  output logic        valid_o,
  output div_t        res_o
);

  logic [31:0] rem_q [DIV_STAGES];
  logic [29:0] quo_q [DIV_STAGES];
  logic [31:0] s_q   [DIV_STAGES];
  mid_t        mid_q [DIV_STAGES];
  logic        v_q   [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    logic [31:0] rem_in, s_in;
    logic [29:0] quo_in;
    mid_t        mid_in;
    logic        v_in;
    logic [32:0] trial;
    logic        take;

    // The dividend below mb carries only zeros, so each step shifts one in.
    if (j == 0) begin : g_first
      assign rem_in = {1'b0, mb_i};
      assign quo_in = '0;
      assign s_in   = s_i;
      assign mid_in = mid_i;
      assign v_in   = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
      assign s_in   = s_q[j-1];
      assign mid_in = mid_q[j-1];
      assign v_in   = v_q[j-1];
    end

    assign trial = {rem_in, 1'b0};
    assign take  = trial >= {1'b0, s_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= take ? 32'(trial - {1'b0, s_in}) : trial[31:0];
        quo_q[j] <= {quo_in[28:0], take};
        s_q[j]   <= s_in;
        mid_q[j] <= mid_in;
      end
    end
  end

  assign valid_o      = v_q[DIV_STAGES-1];
  assign res_o.mid    = mid_q[DIV_STAGES-1];
  assign res_o.wa     = quo_q[DIV_STAGES-1];
  assign res_o.rem_nz = |rem_q[DIV_STAGES-1];

endmodule

// File: rtl/core/crir_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Back pipeline
// Splits impulse and correction by inverse mass, applies them along the
// normal and clamps, in three register stages ending in the output register.
// ----------------------------------------------------------------------------
module crir_back import crir_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  div_t        res_i,
  output logic        valid_o,
  output logic [63:0] new_vel_a_o,
  output logic [63:0] new_vel_b_o,
  output logic [63:0] new_pos_a_o,
  output logic [63:0] new_pos_b_o,
  output logic        impulse_applied_o,
  output logic        saturated_o
);

  // Stage 1: per-body magnitudes.
  logic [30:0] wb_w;
  logic [29:0] wb;
  logic [61:0] da_p, db_p, ca_p, cb_p;

  always_comb begin
    wb_w = 31'h4000_0000 - {1'b0, res_i.wa} - 31'(res_i.rem_nz);
    wb   = wb_w[29:0];
    da_p = 62'(res_i.mid.k) * 62'(res_i.wa);
    db_p = 62'(res_i.mid.k) * 62'(wb);
    ca_p = 62'(res_i.mid.q) * 62'(res_i.wa);
    cb_p = 62'(res_i.mid.q) * 62'(wb);
  end

  logic [31:0] da1_q, db1_q, ca1_q, cb1_q;
  mid_t        mid1_q;

  // Stage 2: one signed step per output component.
  logic [31:0]        mag  [8];
  logic signed [31:0] ncmp [8];
  logic signed [64:0] prod [8];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      ncmp[i] = (i % 2 == 0) ? $signed(mid1_q.normal[63:32]) : $signed(mid1_q.normal[31:0]);
      case (i / 2)
        0:       mag[i] = da1_q;
        1:       mag[i] = db1_q;
        2:       mag[i] = ca1_q;
        default: mag[i] = cb1_q;
      endcase
      prod[i] = 65'($signed({1'b0, mag[i]})) * 65'(ncmp[i]);
    end
  end

  logic signed [48:0] step2_q [8];
  logic [255:0]       base2_q;
  logic               app2_q, sat2_q;

  // Stage 3: move, clamp and register the result.
  logic [31:0] comp_d [8];
  logic        csat_d;

  always_comb begin
    logic signed [49:0] moved;
    logic [32:0]        cl;
    csat_d = 1'b0;
    for (int i = 0; i < 8; i++) begin
      // Body A components move against the normal, body B with it.
      if ((i / 2) % 2 == 0) begin
        moved = 50'($signed(base2_q[255-32*i -: 32])) - 50'(step2_q[i]);
      end else begin
        moved = 50'($signed(base2_q[255-32*i -: 32])) + 50'(step2_q[i]);
      end
      cl        = clamp32(moved);
      comp_d[i] = cl[31:0];
      csat_d    = csat_d | cl[32];
    end
  end

  logic v1_q, v2_q, v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      da1_q  <= da_p[61:30];
      db1_q  <= db_p[61:30];
      ca1_q  <= ca_p[61:30];
      cb1_q  <= cb_p[61:30];
      mid1_q <= res_i.mid;

      for (int i = 0; i < 8; i++) begin
        step2_q[i] <= 49'(prod[i] >>> 16);
      end
      base2_q <= {mid1_q.vel_a, mid1_q.vel_b, mid1_q.pos_a, mid1_q.pos_b};
      app2_q  <= mid1_q.applied;
      sat2_q  <= mid1_q.sat;

      new_vel_a_o       <= {comp_d[0], comp_d[1]};
      new_vel_b_o       <= {comp_d[2], comp_d[3]};
      new_pos_a_o       <= {comp_d[4], comp_d[5]};
      new_pos_b_o       <= {comp_d[6], comp_d[7]};
      impulse_applied_o <= app2_q;
      saturated_o       <= sat2_q | csat_d;
    end
  end

  assign valid_o = v3_q;

endmodule

// File: rtl/core/collision_impulse_response_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collision impulse response, top level
// Resolves one colliding 2D body pair per beat in signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel: valid_i with the pair's fields; a beat is taken at a
//   clock edge with valid_i high and stall_o low.
// - Output channel: valid_o with the updated velocities, centers and flags;
//   a beat leaves at an edge with valid_o high and stall_i low.
// - Configuration: cfg_valid_i/cfg_ready_o write correction percent (index 0)
//   or penetration slop (index 1); write only while the pipeline is empty.
// - From input beat to output beat a pair passes four front stages, thirty
//   stages of the one-bit-per-stage weight divider and three back stages
//   including the output register.
// - Throughput is one pair per cycle while the output is not stalled; every stage advances together.
// - Reset empties the pipeline and loads the register defaults.
// - While a result is held by stall_i, the whole pipeline freezes and stall_o
//   is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module collision_impulse_response_top import crir_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [63:0] vel_a_i,
  input  logic [63:0] vel_b_i,
  input  logic [63:0] pos_a_i,
  input  logic [63:0] pos_b_i,
  input  logic [63:0] normal_i,
  input  logic [30:0] penetration_i,
  input  logic [30:0] mass_a_i,
  input  logic [30:0] mass_b_i,
  input  logic [16:0] restitution_a_i,
  input  logic [16:0] restitution_b_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [63:0] new_vel_a_o,
  output logic [63:0] new_vel_b_o,
  output logic [63:0] new_pos_a_o,
  output logic [63:0] new_pos_b_o,
  output logic        impulse_applied_o,
  output logic        saturated_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  // Configuration registers.
  logic [16:0] pct_q;
  logic [30:0] slop_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_q  <= PERCENT_RST;
      slop_q <= SLOP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_PERCENT: pct_q  <= cfg_data_i[16:0];
        REG_SLOP:    slop_q <= cfg_data_i[30:0];
        default:     ;
      endcase
    end
  end

  // Global advance: hold everything while the output beat is stalled.
  logic en;

  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  logic        f_valid, d_valid;
  mid_t        f_mid;
  logic [30:0] f_mb;
  logic [31:0] f_s;
  div_t        d_res;

  crir_front u_front (
    .clk_i,
    .rst_ni,
    .en_i       (en),
    .valid_i,
    .vel_a_i,
    .vel_b_i,
    .pos_a_i,
    .pos_b_i,
    .normal_i,
    .penetration_i,
    .mass_a_i,
    .mass_b_i,
    .restitution_a_i,
    .restitution_b_i,
    .percent_i  (pct_q),
    .slop_i     (slop_q),
    .valid_o    (f_valid),
    .mid_o      (f_mid),
    .mb_o       (f_mb),
    .s_o        (f_s)
  );

  crir_div u_div (
    .clk_i,
    .rst_ni,
    .en_i    (en),
    .valid_i (f_valid),
    .mid_i   (f_mid),
    .mb_i    (f_mb),
    .s_i     (f_s),
    .valid_o (d_valid),
    .res_o   (d_res)
  );

  crir_back u_back (
    .clk_i,
    .rst_ni,
    .en_i    (en),
    .valid_i (d_valid),
    .res_i   (d_res),
    .valid_o,
    .new_vel_a_o,
    .new_vel_b_o,
    .new_pos_a_o,
    .new_pos_b_o,
    .impulse_applied_o,
    .saturated_o
  );

endmodule

// File: rtl/core/crir_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collision impulse response checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module crir_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        stall_o,
  input logic        valid_o,
  input logic        stall_i,
  input logic [63:0] new_vel_a_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o
);

  // A held output beat stays valid.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> valid_o) else $error("output beat dropped under stall");

  // A held output beat keeps its data.
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> $stable(new_vel_a_o)) else $error("stalled data changed");

  // The block only pushes back when its own output is held.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i)) else $error("input stalled without output stall");

  // Configuration writes are never refused.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o) else $error("configuration write refused");

endmodule

bind collision_impulse_response_top crir_checker u_crir_checker (.*);

// File: dv/tb_collision_impulse_response_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collision impulse response testbench
// Streams colliding pairs through the block under random idle and stall
// bursts. A local predictor works out each updated pair, and the monitor
// compares every output beat with the oldest predicted one, field by field.
// ----------------------------------------------------------------------------
module tb_collision_impulse_response_top;
  import crir_pkg::*;

  typedef struct packed {
    logic [63:0] vel_a;
    logic [63:0] vel_b;
    logic [63:0] pos_a;
    logic [63:0] pos_b;
    logic [63:0] normal;
    logic [30:0] penetration;
    logic [30:0] mass_a;
    logic [30:0] mass_b;
    logic [16:0] rest_a;
    logic [16:0] rest_b;
  } pair_t;

  typedef struct packed {
    logic [63:0] vel_a;
    logic [63:0] vel_b;
    logic [63:0] pos_a;
    logic [63:0] pos_b;
    logic        applied;
    logic        sat;
  } outcome_t;

  typedef logic signed [79:0] wide_t;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 45;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [1:0]  cfg_index_i = REG_PERCENT;
  logic [31:0] cfg_data_i = '0;
  pair_t       cur_pair = '0;
  logic        stall_o, valid_o, cfg_ready_o;
  logic [63:0] new_vel_a_o, new_vel_b_o, new_pos_a_o, new_pos_b_o;
  logic        impulse_applied_o, saturated_o;

  pair_t       pending_pairs[$];
  outcome_t    expected_outcomes[$];
  logic [16:0] percent_q = PERCENT_RST;
  logic [30:0] slop_q = SLOP_RST;
  logic        beat_taken = 1'b0;
  logic        quiet = 1'b0;
  int          send_gap = 0;
  int          stall_left = 0;
  int          errors = 0;
  int unsigned cycles = 0;

  collision_impulse_response_top u_top (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .vel_a_i(cur_pair.vel_a), .vel_b_i(cur_pair.vel_b),
    .pos_a_i(cur_pair.pos_a), .pos_b_i(cur_pair.pos_b),
    .normal_i(cur_pair.normal), .penetration_i(cur_pair.penetration),
    .mass_a_i(cur_pair.mass_a), .mass_b_i(cur_pair.mass_b),
    .restitution_a_i(cur_pair.rest_a), .restitution_b_i(cur_pair.rest_b),
    .valid_o, .stall_i,
    .new_vel_a_o, .new_vel_b_o, .new_pos_a_o, .new_pos_b_o,
    .impulse_applied_o, .saturated_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Clock generation.
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Sign-extend one packed Q16.16 component.
  function automatic wide_t sx(input logic [31:0] w);
    return wide_t'(signed'(w));
  endfunction

  // Move a component by sign * floor(mag * n / 2^16) and clamp it to Q16.16.
  function automatic logic [31:0] nudge(input wide_t p, input wide_t mag, input wide_t n,
                                        input bit add, inout logic sat);
    wide_t step;
    wide_t v;
    step = (mag * n) >>> 16;
    v = add ? p + step : p - step;
    if (v > 80'sd2147483647) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -80'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Predict the resolved pair for the current register settings.
  function automatic outcome_t resolve_pair(input pair_t p, input logic [16:0] pct_r,
                                            input logic [30:0] slop_r);
    outcome_t r;
    wide_t vax, vay, vbx, vby, nx, ny, ma, mb, ra, rb, pct, s, wa, wb;
    wide_t vn, u, k, da, db, d, q, ca, cb;
    logic sat;
    vax = sx(p.vel_a[63:32]); vay = sx(p.vel_a[31:0]);
    vbx = sx(p.vel_b[63:32]); vby = sx(p.vel_b[31:0]);
    nx = sx(p.normal[63:32]); ny = sx(p.normal[31:0]);
    ma = (p.mass_a == 0) ? wide_t'(1) : wide_t'(p.mass_a);
    mb = (p.mass_b == 0) ? wide_t'(1) : wide_t'(p.mass_b);
    ra = (p.rest_a > Q_ONE) ? wide_t'(Q_ONE) : wide_t'(p.rest_a);
    rb = (p.rest_b > Q_ONE) ? wide_t'(Q_ONE) : wide_t'(p.rest_b);
    pct = (pct_r > Q_ONE) ? wide_t'(Q_ONE) : wide_t'(pct_r);
    sat = 1'b0;
    s = ma + mb;
    wa = (mb <<< 30) / s;
    wb = (ma <<< 30) / s;
    vn = (((vbx - vax) * nx) >>> 16) + (((vby - vay) * ny) >>> 16);
    r.applied = (vn <= 0);
    r.vel_a = p.vel_a;
    r.vel_b = p.vel_b;
    // Impulse only for an approaching or resting pair.
    if (r.applied) begin
      u = -vn;
      if (u > 80'sd4294967295) begin
        u = 80'sd4294967295;
        sat = 1'b1;
      end
      k = (u * (65536 + ((ra < rb) ? ra : rb))) >>> 16;
      if (k > 80'sd4294967295) begin
        k = 80'sd4294967295;
        sat = 1'b1;
      end
      da = (k * wa) >>> 30;
      db = (k * wb) >>> 30;
      r.vel_a[63:32] = nudge(vax, da, nx, 1'b0, sat);
      r.vel_a[31:0]  = nudge(vay, da, ny, 1'b0, sat);
      r.vel_b[63:32] = nudge(vbx, db, nx, 1'b1, sat);
      r.vel_b[31:0]  = nudge(vby, db, ny, 1'b1, sat);
    end
    // Positional correction always happens.
    d = (p.penetration > slop_r) ? wide_t'(p.penetration) - wide_t'(slop_r) : 0;
    q = (d * pct) >>> 16;
    ca = (q * wa) >>> 30;
    cb = (q * wb) >>> 30;
    r.pos_a[63:32] = nudge(sx(p.pos_a[63:32]), ca, nx, 1'b0, sat);
    r.pos_a[31:0]  = nudge(sx(p.pos_a[31:0]), ca, ny, 1'b0, sat);
    r.pos_b[63:32] = nudge(sx(p.pos_b[63:32]), cb, nx, 1'b1, sat);
    r.pos_b[31:0]  = nudge(sx(p.pos_b[31:0]), cb, ny, 1'b1, sat);
    r.sat = sat;
    return r;
  endfunction

  function automatic logic [31:0] small_signed(input int unsigned mag);
    return $urandom_range(0, 1) ? 32'($urandom_range(0, mag)) : -32'($urandom_range(0, mag));
  endfunction

  // Build a random pair: mostly plausible contacts, some raw noise.
  function automatic pair_t random_pair();
    pair_t p;
    logic [31:0] nx, ny;
    logic [447:0] raw;
    if ($urandom_range(0, 9) < 2) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      p = raw[$bits(pair_t)-1:0];
      return p;
    end
    case ($urandom_range(0, 5))
      0: begin nx = 32'h0001_0000; ny = 0; end
      1: begin nx = 0; ny = 32'h0001_0000; end
      2: begin nx = 32'hFFFF_0000; ny = 0; end
      3: begin nx = 32'd46341; ny = -32'd46341; end
      default: begin nx = small_signed(65536); ny = small_signed(65536); end
    endcase
    p.normal = {nx, ny};
    p.vel_a = {small_signed(1 << 22), small_signed(1 << 22)};
    p.vel_b = {small_signed(1 << 22), small_signed(1 << 22)};
    p.pos_a = {small_signed(1 << 26), small_signed(1 << 26)};
    p.pos_b = {small_signed(1 << 26), small_signed(1 << 26)};
    p.penetration = 31'($urandom_range(0, 1 << 19));
    p.mass_a = 31'($urandom_range(1 << 10, 1 << 24));
    p.mass_b = 31'($urandom_range(1 << 10, 1 << 24));
    p.rest_a = 17'($urandom_range(0, 65536));
    p.rest_b = 17'($urandom_range(0, 65536));
    return p;
  endfunction

  // Write one register through the configuration port.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_PERCENT) percent_q = data[16:0];
    else if (idx == REG_SLOP) slop_q = data[30:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold the sender until the pipeline is drained, then let it settle.
  task automatic drain();
    do @(posedge clk_i);
    while (pending_pairs.size() != 0 || valid_i || expected_outcomes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) pending_pairs.push_back(random_pair());
  endtask

  // Input driver: one beat per accepted handshake, with random idle bursts.
  always @(negedge clk_i) begin
    if (rst_ni && (!valid_i || beat_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        valid_i <= 1'b0;
      end else if (pending_pairs.size() != 0) begin
        if (!quiet && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 3);
          valid_i <= 1'b0;
        end else begin
          cur_pair <= pending_pairs.pop_front();
          valid_i <= 1'b1;
        end
      end else begin
        valid_i <= 1'b0;
      end
    end
  end

  // Output back-pressure in random bursts.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      stall_i <= 1'b1;
    end else begin
      stall_i <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // Monitor: predict on each input beat, compare on each output beat.
  always @(posedge clk_i) begin
    outcome_t e;
    cycles++;
    beat_taken <= valid_i && !stall_o;
    if (rst_ni && valid_i && !stall_o)
      expected_outcomes.push_back(resolve_pair(cur_pair, percent_q, slop_q));
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_outcomes.size() == 0) begin
        errors++;
        $display("%0t: unexpected output beat, actual vel_a %h", $time, new_vel_a_o);
      end else begin
        e = expected_outcomes.pop_front();
        check_field("new_vel_a", e.vel_a, new_vel_a_o);
        check_field("new_vel_b", e.vel_b, new_vel_b_o);
        check_field("new_pos_a", e.pos_a, new_pos_a_o);
        check_field("new_pos_b", e.pos_b, new_pos_b_o);
        check_field("impulse_applied", 64'(e.applied), 64'(impulse_applied_o));
        check_field("saturated", 64'(e.sat), 64'(saturated_o));
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_collision_impulse_response_top failed");
      $finish;
    end
  end

  // Stimulus phases.
  initial begin
    pair_t p;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed pairs under the reset register values.
    p = '0;
    pending_pairs.push_back(p);                        // all zero, zero masses
    pending_pairs.push_back('1);                       // all ones, oversized fields
    p = '0;
    p.normal = {32'h0001_0000, 32'h0};
    p.vel_a = {32'h0001_0000, 32'h0};                  // head-on approach
    p.mass_a = 31'h10000; p.mass_b = 31'h10000;
    p.rest_a = 17'h10000; p.rest_b = 17'h08000;
    p.penetration = 31'h8000;
    pending_pairs.push_back(p);
    p.vel_a = {32'hFFFF_0000, 32'h0};                  // separating pair
    pending_pairs.push_back(p);
    p.vel_a = {32'h0, 32'h0005_0000};                  // tangential: vn is zero
    pending_pairs.push_back(p);
    p.vel_a = {32'h7FFF_FFFF, 32'h7FFF_FFFF};          // huge impulse
    p.vel_b = {32'h8000_0000, 32'h8000_0000};
    p.normal = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
    pending_pairs.push_back(p);
    p.rest_a = 17'h1FFFF; p.rest_b = 17'h1FFFF;        // restitution above one
    p.mass_a = 31'h7FFF_FFFF; p.mass_b = 31'd0;
    pending_pairs.push_back(p);
    p.normal = {32'h8000_0000, 32'h8000_0000};
    p.pos_a = {32'h8000_0000, 32'h7FFF_FFFF};          // position overflow
    p.pos_b = {32'h7FFF_FFFF, 32'h8000_0000};
    p.penetration = 31'h7FFF_FFFF;
    pending_pairs.push_back(p);
    p.mass_a = 31'd1; p.mass_b = 31'h7FFF_FFFF;
    p.penetration = 31'd6554;                          // exactly the slop
    pending_pairs.push_back(p);
    for (int i = 0; i < 12; i++) pending_pairs.push_back(random_pair());
    push_random(250);
    drain();

    // Full correction, no slop.
    write_reg(REG_PERCENT, 32'd65536);
    write_reg(REG_SLOP, 32'd0);
    push_random(300);
    drain();

    // No correction, largest slop.
    write_reg(REG_PERCENT, 32'd0);
    write_reg(REG_SLOP, 32'hFFFF_FFFF);
    push_random(250);
    drain();

    // Percent above one, random slop.
    write_reg(REG_PERCENT, 32'hFFFF_FFFF);
    write_reg(REG_SLOP, 32'($urandom_range(0, 1 << 18)));
    push_random(300);
    drain();

    // Final part at full rate with no idling.
    write_reg(REG_PERCENT, 32'($urandom_range(0, 65536)));
    write_reg(REG_SLOP, 32'($urandom_range(0, 1 << 16)));
    quiet = 1'b1;
    push_random(280);
    drain();

    if (errors == 0) begin
      $display("tb_collision_impulse_response_top passed");
    end else begin
      $display("tb_collision_impulse_response_top failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/crir_pkg.sv
rtl/core/crir_front.sv
rtl/core/crir_div.sv
rtl/core/crir_back.sv
rtl/core/collision_impulse_response_top.sv
rtl/core/crir_checker.sv
dv/tb_collision_impulse_response_top.sv
